[rtl/lcdw_pkg.sv]
package lcdw_pkg;

    // Item kinds as they arrive on the command channel.
    typedef enum logic [2:0] {
        K_TRACKED   = 3'd0,
        K_UNTRACKED = 3'd1,
        K_SETPOS    = 3'd2,
        K_CLEAR     = 3'd3,
        K_RAW       = 3'd4,
        K_INIT      = 3'd5
    } kind_t;

    // Wait codes that follow an enable pulse.
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_40US = 2'd1;
    localparam logic [1:0] W_2MS  = 2'd2;
    localparam logic [1:0] W_5MS  = 2'd3;

    // Instruction bytes and character codes.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME_MAX = 8'h03;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic       RS_CMD       = 1'b0;
    localparam logic       RS_DATA      = 1'b1;

    // Number of nibbles in the init sequence.
    localparam int INIT_NIBBLES = 14;

    // Type of work carried by a queued job.
    typedef enum logic {
        JOB_BYTES = 1'b0,
        JOB_INIT  = 1'b1
    } job_kind_t;

    // One byte to be sent as two nibbles.
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic [1:0] wait_code;
    } byte_t;

    // One queued job: either one or two bytes, or the init sequence.
    typedef struct packed {
        job_kind_t jkind;
        logic      two_bytes;
        byte_t     b0;
        byte_t     b1;
    } job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // DDRAM base address of each display row.
    function automatic logic [6:0] row_base(input logic [1:0] r);
        logic [6:0] b;
        case (r)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            2'd3:    b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

    // Set-DDRAM-address command; the 7-bit sum wraps as the address mask does.
    function automatic logic [7:0] ddram_cmd(input logic [1:0] r, input logic [4:0] c);
        logic [6:0] addr;
        addr = row_base(r) + {2'b00, c};
        return {1'b1, addr};
    endfunction

    // Init sequence, one nibble and its wait code per step.
    function automatic logic [5:0] init_step(input logic [3:0] idx);
        logic [5:0] s;
        case (idx)
            4'd0:    s = {4'h3, W_5MS};
            4'd1:    s = {4'h3, W_2MS};
            4'd2:    s = {4'h3, W_40US};
            4'd3:    s = {4'h2, W_40US};
            4'd4:    s = {4'h2, W_NONE};
            4'd5:    s = {4'h8, W_40US};
            4'd6:    s = {4'h0, W_NONE};
            4'd7:    s = {4'h8, W_40US};
            4'd8:    s = {4'h0, W_NONE};
            4'd9:    s = {4'h1, W_2MS};
            4'd10:   s = {4'h0, W_NONE};
            4'd11:   s = {4'h6, W_40US};
            4'd12:   s = {4'h0, W_NONE};
            4'd13:   s = {4'hE, W_40US};
            default: s = {4'h0, W_NONE};
        endcase
        return s;
    endfunction

endpackage

[rtl/lcdw_ifs.sv]
// Command channel: one display item per transaction.
interface lcdw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [1:0] row;
    logic [4:0] col;

    modport source (output valid, kind, char_code, row, col, input ready);
    modport sink   (input valid, kind, char_code, row, col, output ready);
endinterface

// Bus channel: one nibble per transaction.
interface lcdw_bus_if;
    logic       valid;
    logic       ready;
    logic       rs;
    logic [3:0] nibble;
    logic [1:0] wait_code;
    logic       last;

    modport source (output valid, rs, nibble, wait_code, last, input ready);
    modport sink   (input valid, rs, nibble, wait_code, last, output ready);
endinterface

[rtl/lcdw_front.sv]
module lcdw_front #(
    parameter int ROWS = 4,
    parameter int COLS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lcdw_cmd_if.sink               cmd,
    input  lcdw_pkg::fifo_stat_t   qstat,
    output logic                   push,
    output lcdw_pkg::job_t         job
);

    localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);
    localparam logic [4:0] COL_END  = 5'(COLS);

    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [4:0] cursor_col_reg, cursor_col_next;
    logic [1:0] wrap_row;
    logic       accept;
    logic       known;

    // The queue has room: take the item.
    assign cmd.ready = !qstat.full;
    assign accept    = cmd.valid && cmd.ready;
    assign push      = accept && known;

    // Row that follows the cursor row, wrapping after the last one.
    assign wrap_row = (cursor_row_reg < LAST_ROW) ? cursor_row_reg + 2'd1 : 2'd0;

    // Classify the item into a job and work out the new cursor.
    always_comb
    begin
        known           = 1'b1;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        job.jkind       = lcdw_pkg::JOB_BYTES;
        job.two_bytes   = 1'b0;
        job.b0          = '{rs: lcdw_pkg::RS_DATA, data: cmd.char_code,
                            wait_code: lcdw_pkg::W_40US};
        job.b1          = '{rs: lcdw_pkg::RS_DATA, data: cmd.char_code,
                            wait_code: lcdw_pkg::W_40US};
        case (cmd.kind)
            lcdw_pkg::K_TRACKED:
            begin
                if (cmd.char_code == lcdw_pkg::CHAR_NEWLINE)
                begin
                    cursor_row_next = wrap_row;
                    cursor_col_next = 5'd0;
                    job.b0 = '{rs: lcdw_pkg::RS_CMD,
                               data: lcdw_pkg::ddram_cmd(wrap_row, 5'd0),
                               wait_code: lcdw_pkg::W_40US};
                end
                else if (cursor_col_reg >= COL_END)
                begin
                    // Row full: move to the next row before the character.
                    cursor_row_next = wrap_row;
                    cursor_col_next = 5'd1;
                    job.two_bytes   = 1'b1;
                    job.b0 = '{rs: lcdw_pkg::RS_CMD,
                               data: lcdw_pkg::ddram_cmd(wrap_row, 5'd0),
                               wait_code: lcdw_pkg::W_40US};
                end
                else
                begin
                    cursor_col_next = cursor_col_reg + 5'd1;
                end
            end
            lcdw_pkg::K_UNTRACKED:
            begin
                known = 1'b1;
            end
            lcdw_pkg::K_SETPOS:
            begin
                cursor_row_next = cmd.row;
                cursor_col_next = cmd.col;
                job.b0 = '{rs: lcdw_pkg::RS_CMD,
                           data: lcdw_pkg::ddram_cmd(cmd.row, cmd.col),
                           wait_code: lcdw_pkg::W_40US};
            end
            lcdw_pkg::K_CLEAR:
            begin
                cursor_row_next = 2'd0;
                cursor_col_next = 5'd0;
                job.b0 = '{rs: lcdw_pkg::RS_CMD, data: lcdw_pkg::CMD_CLEAR,
                           wait_code: lcdw_pkg::W_2MS};
            end
            lcdw_pkg::K_RAW:
            begin
                // Clear and home need the long wait.
                job.b0.rs = lcdw_pkg::RS_CMD;
                if (cmd.char_code != 8'd0 && cmd.char_code <= lcdw_pkg::CMD_HOME_MAX)
                begin
                    job.b0.wait_code = lcdw_pkg::W_2MS;
                end
            end
            lcdw_pkg::K_INIT:
            begin
                cursor_row_next = 2'd0;
                cursor_col_next = 5'd0;
                job.jkind       = lcdw_pkg::JOB_INIT;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Cursor registers change only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 2'd0;
            cursor_col_reg <= 5'd0;
        end
        else if (push)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule

[rtl/lcdw_fifo.sv]
module lcdw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lcdw_pkg::job_t       push_data,
    input  logic                 pop,
    output lcdw_pkg::job_t       pop_data,
    output lcdw_pkg::fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    lcdw_pkg::job_t slots_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign pop_data   = slots_reg[rd_ptr_reg];

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[rtl/lcdw_back.sv]
module lcdw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcdw_pkg::fifo_stat_t qstat,
    input  lcdw_pkg::job_t       head,
    output logic                 pop,
    lcdw_bus_if.source           bus
);

    lcdw_pkg::job_t job_reg;
    logic           job_valid_reg;
    logic [3:0]     idx_reg;

    logic           bus_valid_reg;
    logic           rs_reg;
    logic [3:0]     nibble_reg;
    logic [1:0]     wait_reg;
    logic           last_reg;

    logic           load;
    logic [3:0]     last_idx;
    logic           is_last;
    lcdw_pkg::byte_t cur_byte;
    logic [5:0]     init_s;
    logic           nib_rs;
    logic [3:0]     nib_val;
    logic [1:0]     nib_wait;

    // A nibble moves into the output register when that register is free.
    assign load = job_valid_reg && (!bus_valid_reg || bus.ready);

    // Index of the final nibble of the current job.
    always_comb
    begin
        if (job_reg.jkind == lcdw_pkg::JOB_INIT)
        begin
            last_idx = 4'(lcdw_pkg::INIT_NIBBLES - 1);
        end
        else if (job_reg.two_bytes)
        begin
            last_idx = 4'd3;
        end
        else
        begin
            last_idx = 4'd1;
        end
    end
    assign is_last = (idx_reg == last_idx);

    // Take the next job when idle or when the current one finishes.
    assign pop = !qstat.empty && (!job_valid_reg || (load && is_last));

    // Select the nibble at the current step: high half of a byte first.
    assign cur_byte = idx_reg[1] ? job_reg.b1 : job_reg.b0;
    assign init_s   = lcdw_pkg::init_step(idx_reg);
    always_comb
    begin
        if (job_reg.jkind == lcdw_pkg::JOB_INIT)
        begin
            nib_rs   = lcdw_pkg::RS_CMD;
            nib_val  = init_s[5:2];
            nib_wait = init_s[1:0];
        end
        else if (!idx_reg[0])
        begin
            nib_rs   = cur_byte.rs;
            nib_val  = cur_byte.data[7:4];
            nib_wait = lcdw_pkg::W_NONE;
        end
        else
        begin
            nib_rs   = cur_byte.rs;
            nib_val  = cur_byte.data[3:0];
            nib_wait = cur_byte.wait_code;
        end
    end

    // Job register and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else if (pop)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= 4'd0;
        end
        else if (load)
        begin
            job_valid_reg <= !is_last;
            idx_reg       <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            bus_valid_reg <= 1'b1;
        end
        else if (bus.ready)
        begin
            bus_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg     <= nib_rs;
            nibble_reg <= nib_val;
            wait_reg   <= nib_wait;
            last_reg   <= is_last;
        end
    end

    assign bus.valid     = bus_valid_reg;
    assign bus.rs        = rs_reg;
    assign bus.nibble    = nibble_reg;
    assign bus.wait_code = wait_reg;
    assign bus.last      = last_reg;

endmodule

[rtl/char_lcd_text_writer_unit.sv]
// Text writer for a character LCD on a 4-bit bus. Each command transaction
// (tracked or untracked character, set position, clear, raw instruction or
// init) becomes a run of bus transactions, one nibble each, high nibble of a
// byte first, with the register-select level, a wait code for the pulse
// timer and a last flag on the final nibble. The block keeps the cursor so
// that tracked characters wrap at the end of a row and newline moves to the
// start of the next row; the power-on wait belongs to the environment. The
// back end sends one nibble per cycle from its output register while the bus
// is ready: an item becomes 2 nibbles (one byte), 4 (row wrap plus character)
// or 14 (init), and that serializer sets the sustained rate. The front end
// classifies one item per cycle while the queue has room into a job queue of
// QUEUE_DEPTH entries, so new items are taken while earlier ones are still
// being sent. Kinds 6 and 7 are taken and ignored.
module char_lcd_text_writer_unit #(
    parameter int ROWS        = 4,
    parameter int COLS        = 20,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    lcdw_cmd_if.sink   cmd,
    lcdw_bus_if.source bus
);

    lcdw_pkg::fifo_stat_t qstat;
    lcdw_pkg::job_t       push_job;
    lcdw_pkg::job_t       head_job;
    logic                 push;
    logic                 pop;

    // Front end: accept, classify, track the cursor.
    lcdw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .qstat (qstat),
        .push  (push),
        .job   (push_job)
    );

    // Job queue between the two halves.
    lcdw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (head_job),
        .stat      (qstat)
    );

    // Back end: serialize jobs into nibbles.
    lcdw_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qstat (qstat),
        .head  (head_job),
        .pop   (pop),
        .bus   (bus)
    );

`ifndef SYNTHESIS
    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job queue read while empty");

    // Unused kinds are accepted but never queued.
    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.kind > lcdw_pkg::K_INIT)) |-> !push)
        else $error("unused kind queued a job");

    // A stalled bus transaction keeps its payload until it is taken.
    a_bus_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (bus.valid && !bus.ready) |=>
            (bus.valid && $stable({bus.rs, bus.nibble, bus.wait_code, bus.last})))
        else $error("bus transaction changed while stalled");
`endif

endmodule

[bench/lcd_nibble_checker.sv]
`timescale 1ns / 100ps

// Watches the command and bus channels of the LCD text writer. It predicts the
// nibble stream for every accepted command transaction and compares each bus
// transaction with the oldest predicted nibble.
module lcd_nibble_checker #(
    parameter int ROWS = 4,
    parameter int COLS = 20
) (
    input  logic clk,
    input  logic rst_n,
    lcdw_cmd_if  cmd,
    lcdw_bus_if  bus,
    output int   mismatch_count,
    output int   nibbles_due,
    output int   items_taken,
    output int   nibbles_seen,
    output int   row_wraps
);

    // Instruction bytes of the power-on sequence and the DDRAM address command.
    localparam logic [7:0] DDRAM_SET     = 8'h80;
    localparam logic [7:0] FUNC_4BIT_2LN = 8'h28;
    localparam logic [7:0] DISPLAY_OFF   = 8'h08;
    localparam logic [7:0] ENTRY_INC     = 8'h06;
    localparam logic [7:0] DISPLAY_CURS  = 8'h0E;
    localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
    localparam logic [3:0] BUS4_NIBBLE   = 4'h2;

    // Start address of each display row in DDRAM.
    localparam logic [6:0] LINE_START [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [1:0] wait_code;
        logic       last;
    } lcd_nibble_t;

    lcd_nibble_t pending_nibbles [$];
    lcd_nibble_t held_nibble;
    logic        holding;
    logic [1:0]  cur_row;
    logic [4:0]  cur_col;

    // The newest nibble is held back so the final one of a command can be flagged.
    task automatic put_nibble(input logic rs, input logic [3:0] nib, input logic [1:0] wc);
        if (holding)
            pending_nibbles.push_back(held_nibble);
        held_nibble.rs        = rs;
        held_nibble.nibble    = nib;
        held_nibble.wait_code = wc;
        held_nibble.last      = 1'b0;
        holding               = 1'b1;
    endtask

    task automatic put_byte(input logic rs, input logic [7:0] b, input logic [1:0] wc);
        put_nibble(rs, b[7:4], lcdw_pkg::W_NONE);
        put_nibble(rs, b[3:0], wc);
    endtask

    // Set-DDRAM command for the current cursor; the sum wraps at 7 bits.
    task automatic put_cursor_addr();
        logic [6:0] addr;
        addr = LINE_START[cur_row] + {2'b00, cur_col};
        put_byte(lcdw_pkg::RS_CMD, DDRAM_SET | {1'b0, addr}, lcdw_pkg::W_40US);
    endtask

    task automatic advance_row();
        if (int'(cur_row) < ROWS - 1)
            cur_row = cur_row + 2'd1;
        else
            cur_row = 2'd0;
        cur_col = 5'd0;
        put_cursor_addr();
    endtask

    // Expected nibble stream of one command transaction.
    task automatic predict_nibbles(input logic [2:0] kind, input logic [7:0] ch,
                                   input logic [1:0] row, input logic [4:0] col);
        holding = 1'b0;
        case (kind)
            lcdw_pkg::K_TRACKED:
            begin
                if (ch == lcdw_pkg::CHAR_NEWLINE)
                    advance_row();
                else
                begin
                    if (int'(cur_col) >= COLS)
                    begin
                        advance_row();
                        row_wraps++;
                    end
                    put_byte(lcdw_pkg::RS_DATA, ch, lcdw_pkg::W_40US);
                    cur_col = cur_col + 5'd1;
                end
            end
            lcdw_pkg::K_UNTRACKED:
                put_byte(lcdw_pkg::RS_DATA, ch, lcdw_pkg::W_40US);
            lcdw_pkg::K_SETPOS:
            begin
                cur_row = row;
                cur_col = col;
                put_cursor_addr();
            end
            lcdw_pkg::K_CLEAR:
            begin
                put_byte(lcdw_pkg::RS_CMD, lcdw_pkg::CMD_CLEAR, lcdw_pkg::W_2MS);
                cur_row = 2'd0;
                cur_col = 5'd0;
            end
            lcdw_pkg::K_RAW:
                put_byte(lcdw_pkg::RS_CMD, ch,
                         (ch >= lcdw_pkg::CMD_CLEAR && ch <= lcdw_pkg::CMD_HOME_MAX)
                             ? lcdw_pkg::W_2MS : lcdw_pkg::W_40US);
            lcdw_pkg::K_INIT:
            begin
                put_nibble(lcdw_pkg::RS_CMD, WAKE_NIBBLE, lcdw_pkg::W_5MS);
                put_nibble(lcdw_pkg::RS_CMD, WAKE_NIBBLE, lcdw_pkg::W_2MS);
                put_nibble(lcdw_pkg::RS_CMD, WAKE_NIBBLE, lcdw_pkg::W_40US);
                put_nibble(lcdw_pkg::RS_CMD, BUS4_NIBBLE, lcdw_pkg::W_40US);
                put_byte(lcdw_pkg::RS_CMD, FUNC_4BIT_2LN, lcdw_pkg::W_40US);
                put_byte(lcdw_pkg::RS_CMD, DISPLAY_OFF, lcdw_pkg::W_40US);
                put_byte(lcdw_pkg::RS_CMD, lcdw_pkg::CMD_CLEAR, lcdw_pkg::W_2MS);
                put_byte(lcdw_pkg::RS_CMD, ENTRY_INC, lcdw_pkg::W_40US);
                put_byte(lcdw_pkg::RS_CMD, DISPLAY_CURS, lcdw_pkg::W_40US);
                cur_row = 2'd0;
                cur_col = 5'd0;
            end
            default:
                ;
        endcase
        if (holding)
        begin
            held_nibble.last = 1'b1;
            pending_nibbles.push_back(held_nibble);
        end
    endtask

    // Compare one bus transaction with the oldest predicted nibble.
    task automatic check_nibble();
        lcd_nibble_t want;
        nibbles_seen++;
        if (pending_nibbles.size() == 0)
        begin
            $error("unexpected bus transaction: rs %0d nibble %0h wait_code %0d last %0d",
                   bus.rs, bus.nibble, bus.wait_code, bus.last);
            mismatch_count++;
        end
        else
        begin
            want = pending_nibbles.pop_front();
            if (bus.rs !== want.rs)
            begin
                $error("rs: expected %0d, actual %0d", want.rs, bus.rs);
                mismatch_count++;
            end
            if (bus.nibble !== want.nibble)
            begin
                $error("nibble: expected %0h, actual %0h", want.nibble, bus.nibble);
                mismatch_count++;
            end
            if (bus.wait_code !== want.wait_code)
            begin
                $error("wait_code: expected %0d, actual %0d", want.wait_code, bus.wait_code);
                mismatch_count++;
            end
            if (bus.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, bus.last);
                mismatch_count++;
            end
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_nibbles.delete();
            holding        = 1'b0;
            cur_row        = 2'd0;
            cur_col        = 5'd0;
            mismatch_count = 0;
            items_taken    = 0;
            nibbles_seen   = 0;
            row_wraps      = 0;
            nibbles_due    = 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                items_taken++;
                predict_nibbles(cmd.kind, cmd.char_code, cmd.row, cmd.col);
            end
            if (bus.valid && bus.ready)
                check_nibble();
            nibbles_due = pending_nibbles.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int         RANDOM_ITEMS = 425;
    localparam int         PAUSE_EVERY  = 90;
    localparam int         SETTLE       = 48;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [7:0] CHAR_FIRST   = 8'h20;
    localparam logic [7:0] CHAR_FINAL   = 8'h7E;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE,
        RX_BURSTY
    } rx_mode_t;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   nibbles_due;
    int   items_taken;
    int   nibbles_seen;
    int   row_wraps;
    int   burst_left;
    int   cycle_count;

    lcdw_cmd_if cmd_ch ();
    lcdw_bus_if bus_ch ();

    char_lcd_text_writer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .bus   (bus_ch)
    );

    lcd_nibble_checker nibble_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .bus            (bus_ch),
        .mismatch_count (mismatch_count),
        .nibbles_due    (nibbles_due),
        .items_taken    (items_taken),
        .nibbles_seen   (nibbles_seen),
        .row_wraps      (row_wraps)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Run timeout.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("char_lcd_text_writer_unit regression: fail");
        $finish;
    end

    // Bus receiver: ready follows a stall mode that changes every so often.
    initial
    begin : rx_stall
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        bus_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 4));
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (mode)
                RX_OPEN:   bus_ch.ready <= 1'b1;
                RX_MOSTLY: bus_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: bus_ch.ready <= ($urandom_range(0, 3) == 0);
                RX_TOGGLE: bus_ch.ready <= ~bus_ch.ready;
                default:
                begin
                    if (hold_left != 0)
                    begin
                        bus_ch.ready <= 1'b0;
                        hold_left--;
                    end
                    else
                    begin
                        bus_ch.ready <= 1'b1;
                        hold_left = $urandom_range(2, 12);
                    end
                end
            endcase
        end
    end

    // Send one command transaction, with a random gap at the end of a burst.
    task automatic send_item(input logic [2:0] kind, input logic [7:0] ch,
                             input logic [1:0] row, input logic [4:0] col);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                cmd_ch.valid     <= 1'b0;
                cmd_ch.kind      <= 3'($urandom);
                cmd_ch.char_code <= 8'($urandom);
                cmd_ch.row       <= 2'($urandom);
                cmd_ch.col       <= 5'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= kind;
        cmd_ch.char_code <= ch;
        cmd_ch.row       <= row;
        cmd_ch.col       <= col;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Hold the sender off until every predicted nibble has been seen.
    task automatic wait_display_idle();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (nibbles_due != 0)
            @(posedge clk);
    endtask

    // A mostly printable character, sometimes a newline or any byte.
    function automatic logic [7:0] text_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return lcdw_pkg::CHAR_NEWLINE;
        else if (pick <= 2)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(CHAR_FIRST, CHAR_FINAL));
    endfunction

    // Reset, directed commands, random traffic and the verdict.
    initial
    begin : stimulus
        int counted;
        int next_pause;
        int pick;
        logic [4:0] col;
        counted    = 0;
        next_pause = PAUSE_EVERY;
        burst_left = 0;
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.kind      <= lcdw_pkg::K_TRACKED;
        cmd_ch.char_code <= 8'h00;
        cmd_ch.row       <= 2'd0;
        cmd_ch.col       <= 5'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: init, character extremes, newline, addresses, wraps, clears.
        send_item(lcdw_pkg::K_INIT, 8'hFF, 2'd3, 5'd31);
        send_item(lcdw_pkg::K_TRACKED, 8'h41, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_TRACKED, 8'h00, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_TRACKED, 8'hFF, 2'd3, 5'd31);
        send_item(lcdw_pkg::K_TRACKED, lcdw_pkg::CHAR_NEWLINE, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_UNTRACKED, lcdw_pkg::CHAR_NEWLINE, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_UNTRACKED, 8'hFF, 2'd3, 5'd31);
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd1, 5'd31);
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd2, 5'd31);
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd0, 5'd0);
        // Column beyond the row end forces a wrap from the last row to the first.
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd3, 5'd31);
        send_item(lcdw_pkg::K_TRACKED, 8'h5A, 2'd0, 5'd0);
        // Filling the last column and writing one more wraps as well.
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd3, 5'd19);
        send_item(lcdw_pkg::K_TRACKED, 8'h78, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_TRACKED, 8'h79, 2'd0, 5'd0);
        // Newline on the last row goes back to the first.
        send_item(lcdw_pkg::K_SETPOS, 8'h00, 2'd3, 5'd5);
        send_item(lcdw_pkg::K_TRACKED, lcdw_pkg::CHAR_NEWLINE, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_CLEAR, 8'hFF, 2'd3, 5'd31);
        send_item(lcdw_pkg::K_RAW, 8'h01, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_RAW, 8'h02, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_RAW, 8'h03, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_RAW, 8'h00, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_RAW, 8'h04, 2'd0, 5'd0);
        send_item(lcdw_pkg::K_RAW, 8'hFF, 2'd0, 5'd0);
        send_item(KIND_SPARE_A, 8'hFF, 2'd3, 5'd31);
        send_item(KIND_SPARE_B, 8'h00, 2'd0, 5'd0);
        wait_display_idle();

        // Random traffic, mostly text with cursor moves and occasional commands.
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= next_pause)
            begin
                wait_display_idle();
                next_pause += PAUSE_EVERY;
            end
            pick = $urandom_range(0, 99);
            col  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(20, 31))
                                               : 5'($urandom_range(0, 19));
            if (pick < 55)
                send_item(lcdw_pkg::K_TRACKED, text_char(), 2'($urandom), 5'($urandom));
            else if (pick < 65)
                send_item(lcdw_pkg::K_UNTRACKED, 8'($urandom), 2'($urandom), 5'($urandom));
            else if (pick < 77)
                send_item(lcdw_pkg::K_SETPOS, 8'($urandom), 2'($urandom), col);
            else if (pick < 82)
                send_item(lcdw_pkg::K_CLEAR, 8'($urandom), 2'($urandom), 5'($urandom));
            else if (pick < 92)
                send_item(lcdw_pkg::K_RAW,
                          ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 4))
                                                      : 8'($urandom),
                          2'($urandom), 5'($urandom));
            else if (pick < 96)
                send_item(lcdw_pkg::K_INIT, 8'($urandom), 2'($urandom), 5'($urandom));
            else
                send_item(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B,
                          8'($urandom), 2'($urandom), 5'($urandom));
            if (pick < 96)
                counted++;
        end

        // Drain, let the block settle, then report.
        wait_display_idle();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d command transactions, %0d nibble transactions checked, %0d row wraps,",
                 items_taken, nibbles_seen, row_wraps);
        $display("with bursty commands, a stalling bus and several drains to idle.");
        if (mismatch_count == 0 && nibbles_due == 0)
            $display("char_lcd_text_writer_unit regression: pass");
        else
            $display("char_lcd_text_writer_unit regression: fail");
        $finish;
    end

endmodule

[char_lcd_text_writer_unit.f]
rtl/lcdw_pkg.sv
rtl/lcdw_ifs.sv
rtl/lcdw_front.sv
rtl/lcdw_fifo.sv
rtl/lcdw_back.sv
rtl/char_lcd_text_writer_unit.sv
bench/lcd_nibble_checker.sv
bench/testbench.sv
